[src/bam_pkg.sv]
`default_nettype none
package bam_pkg;

  localparam logic [16:0] FIXED_ONE = 17'd65536;

  typedef struct packed {
    logic [3:0]  arm_index;
    logic [16:0] reward;
  } item_t;

  typedef struct packed {
    logic [3:0]  best_arm;
    logic [16:0] updated_mean;
    logic [31:0] updated_count;
    logic [47:0] total_gain;
  } result_t;

  typedef logic [2:0] step_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_WRITE,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_ITEM,
    C_OUT_RANGE,
    C_DIV_BUSY,
    C_SCAN_BUSY,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  localparam step_t STEP_WAIT      = 3'd0;
  localparam step_t STEP_MUL       = 3'd1;
  localparam step_t STEP_DIV_INIT  = 3'd2;
  localparam step_t STEP_DIV       = 3'd3;
  localparam step_t STEP_WRITE     = 3'd4;
  localparam step_t STEP_SCAN_INIT = 3'd5;
  localparam step_t STEP_SCAN      = 3'd6;
  localparam step_t STEP_EMIT      = 3'd7;

  // control store; a step that does not jump falls to the next one
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    unique case (s)
      STEP_WAIT:      w = '{op: OP_LOAD,      cond: C_NO_ITEM,   target: STEP_WAIT};
      STEP_MUL:       w = '{op: OP_MUL,       cond: C_OUT_RANGE, target: STEP_SCAN_INIT};
      STEP_DIV_INIT:  w = '{op: OP_DIV_INIT,  cond: C_NEVER,     target: STEP_WAIT};
      STEP_DIV:       w = '{op: OP_DIV_STEP,  cond: C_DIV_BUSY,  target: STEP_DIV};
      STEP_WRITE:     w = '{op: OP_WRITE,     cond: C_NEVER,     target: STEP_WAIT};
      STEP_SCAN_INIT: w = '{op: OP_SCAN_INIT, cond: C_NEVER,     target: STEP_WAIT};
      STEP_SCAN:      w = '{op: OP_SCAN,      cond: C_SCAN_BUSY, target: STEP_SCAN};
      STEP_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_BUSY,  target: STEP_EMIT};
      default:        w = '{op: OP_LOAD,      cond: C_NO_ITEM,   target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[src/bam_ram.sv]
`default_nettype none
module bam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/bandit_arm_mean_tracker.sv]
// channel | fields                                          | handshake
// item    | arm_index, reward                               | item_valid / item_stall
// result  | best_arm, updated_mean, updated_count, total_gain | result_valid / result_stall
//
// Each item runs a 17-step restoring divide (skipped for an out-of-range arm)
// and a scan of every arm through the single read port of the arm table.
// The result register frees the sequencer, so the next item is taken while a
// result is still stalled; a stalled result holds the sequencer at its last step.
// Reset clears the per-arm valid bits, the total, the step, rd_valid and result_valid;
// an arm whose valid bit is clear reads as mean and count zero.
`default_nettype none
module bandit_arm_mean_tracker
  import bam_pkg::*;
#(
  parameter int NUM_ARMS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  localparam int AW = $clog2(NUM_ARMS);
  localparam logic [AW-1:0] LAST = AW'(NUM_ARMS - 1);

  step_t  step;
  step_t  step_next;
  uword_t uw;

  logic [AW-1:0]      arm_addr;
  logic               in_range;
  logic [16:0]        rwd;
  logic [31:0]        count_cur;
  logic [49:0]        num;
  logic [32:0]        dvs;
  logic [32:0]        rem;
  logic [16:0]        low;
  logic [4:0]         div_cnt;
  logic [47:0]        total;
  logic [16:0]        new_mean;
  logic [31:0]        new_count;
  logic [AW-1:0]      scan_idx;
  logic [AW-1:0]      best_idx;
  logic [16:0]        best_mean;
  logic [(1<<AW)-1:0] valid;
  logic               rd_valid;

  logic [AW-1:0] raddr;
  logic          we;
  logic [48:0]   rdata;
  logic [16:0]   mean_eff;
  logic [31:0]   count_eff;
  logic [48:0]   prod;
  logic [33:0]   trial;
  logic          qbit;
  logic [48:0]   tsum;
  logic [31:0]   count_sat;
  logic          jump;
  logic          take;

  logic [AW+3:0] arm_wide;
  logic [AW-1:0] item_addr;
  logic [AW+3:0] best_wide;

  assign uw         = ucode(step);
  assign item_stall = (step != STEP_WAIT);
  assign take       = item_valid && !item_stall;

  assign arm_wide  = {{AW{1'b0}}, item.arm_index};
  assign item_addr = arm_wide[AW-1:0];
  assign best_wide = {4'b0000, best_idx};

  assign mean_eff  = rd_valid ? rdata[48:32] : 17'd0;
  assign count_eff = rd_valid ? rdata[31:0] : 32'd0;
  assign prod      = mean_eff * count_eff;
  assign trial     = {rem, low[16]};
  assign qbit      = (trial >= {1'b0, dvs});
  assign tsum      = {1'b0, total} + {32'd0, rwd};
  assign count_sat = (count_cur == '1) ? count_cur : count_cur + 32'd1;
  assign we        = (uw.op == OP_WRITE);

  always_comb begin
    unique case (uw.op)
      OP_LOAD:      raddr = item_addr;
      OP_SCAN_INIT: raddr = '0;
      OP_SCAN:      raddr = scan_idx + AW'(1);
      default:      raddr = arm_addr;
    endcase
  end

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     jump = 1'b0;
      C_NO_ITEM:   jump = !item_valid;
      C_OUT_RANGE: jump = !in_range;
      C_DIV_BUSY:  jump = (div_cnt != 5'd0);
      C_SCAN_BUSY: jump = (scan_idx != LAST);
      C_OUT_BUSY:  jump = result_valid && result_stall;
      default:     jump = 1'b0;
    endcase
    step_next = jump ? uw.target : step + 3'd1;
  end

  bam_ram #(
    .WIDTH(49),
    .DEPTH(NUM_ARMS)
  ) u_arms (
    .clk  (clk),
    .we   (we),
    .waddr(arm_addr),
    .wdata({low, count_sat}),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= STEP_WAIT;
      valid        <= '0;
      total        <= '0;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      step     <= step_next;
      rd_valid <= valid[raddr];
      if (we) begin
        valid[arm_addr] <= 1'b1;
        total <= tsum[48] ? '1 : tsum[47:0];
      end
      if (uw.op == OP_EMIT && !jump) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uw.op)
      OP_LOAD: begin
        if (take) begin
          arm_addr  <= item_addr;
          in_range  <= (arm_wide < (AW+4)'(NUM_ARMS));
          rwd       <= (item.reward > FIXED_ONE) ? FIXED_ONE : item.reward;
          new_mean  <= '0;
          new_count <= '0;
        end
      end
      OP_MUL: begin
        num       <= {1'b0, prod} + {33'd0, rwd};
        dvs       <= {1'b0, count_eff} + 33'd1;
        count_cur <= count_eff;
      end
      OP_DIV_INIT: begin
        rem     <= num[49:17];
        low     <= num[16:0];
        div_cnt <= 5'd16;
      end
      OP_DIV_STEP: begin
        rem     <= qbit ? 33'(trial - {1'b0, dvs}) : trial[32:0];
        low     <= {low[15:0], qbit};
        div_cnt <= div_cnt - 5'd1;
      end
      OP_WRITE: begin
        new_mean  <= low;
        new_count <= count_sat;
      end
      OP_SCAN_INIT: begin
        scan_idx <= '0;
      end
      OP_SCAN: begin
        scan_idx <= scan_idx + AW'(1);
        if (scan_idx == '0 || mean_eff > best_mean) begin
          best_mean <= mean_eff;
          best_idx  <= scan_idx;
        end
      end
      OP_EMIT: begin
        if (!jump) begin
          result.best_arm      <= best_wide[3:0];
          result.updated_mean  <= new_mean;
          result.updated_count <= new_count;
          result.total_gain    <= total;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[bench/tb_bandit_arm_mean_tracker.sv]
`default_nettype none
module tb_bandit_arm_mean_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import bam_pkg::*;

  localparam int ARM_COUNT   = 16;
  localparam int STUCK_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 200;

  class arm_mean_scoreboard;
    logic [16:0] means [ARM_COUNT];
    logic [31:0] counts [ARM_COUNT];
    logic [47:0] total;
    result_t     pending_q [$];
    int          errors;
    int          pulls;
    int          checked;
    int          clamped;

    function new();
      foreach (means[k]) begin
        means[k]  = '0;
        counts[k] = '0;
      end
      total   = '0;
      errors  = 0;
      pulls   = 0;
      checked = 0;
      clamped = 0;
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    function void note_pull(item_t it);
      logic [16:0] r;
      logic [48:0] sum;
      logic [63:0] num;
      logic [63:0] quo;
      result_t     exp;
      int          a;
      int          best;
      r = it.reward;
      if (r > FIXED_ONE) begin
        r = FIXED_ONE;
        clamped++;
      end
      exp = '0;
      a = int'(it.arm_index);
      if (a < ARM_COUNT) begin
        num = 64'(means[a]) * 64'(counts[a]) + 64'(r);
        quo = num / (64'(counts[a]) + 64'd1);
        sum = {1'b0, total} + 49'(r);
        total = sum[48] ? '1 : sum[47:0];
        means[a] = quo[16:0];
        if (counts[a] != '1) counts[a] = counts[a] + 32'd1;
        exp.updated_mean  = means[a];
        exp.updated_count = counts[a];
      end
      best = 0;
      for (int k = 1; k < ARM_COUNT; k++) begin
        if (means[k] > means[best]) best = k;
      end
      exp.best_arm   = 4'(best);
      exp.total_gain = total;
      pending_q.push_back(exp);
      pulls++;
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: best_arm %0d mean %0d count %0d total %0d",
               got.best_arm, got.updated_mean, got.updated_count, got.total_gain);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      checked++;
      if (got.best_arm !== exp.best_arm) begin
        $error("best_arm: expected %0d, actual %0d", exp.best_arm, got.best_arm);
        errors++;
      end
      if (got.updated_mean !== exp.updated_mean) begin
        $error("updated_mean: expected %0d, actual %0d", exp.updated_mean, got.updated_mean);
        errors++;
      end
      if (got.updated_count !== exp.updated_count) begin
        $error("updated_count: expected %0d, actual %0d", exp.updated_count,
               got.updated_count);
        errors++;
      end
      if (got.total_gain !== exp.total_gain) begin
        $error("total_gain: expected %0d, actual %0d", exp.total_gain, got.total_gain);
        errors++;
      end
    endfunction
  endclass

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  arm_mean_scoreboard sb;
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int burst_left = 0;
  int stuck_cycles = 0;

  bandit_arm_mean_tracker #(
    .NUM_ARMS(ARM_COUNT)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_pull(item);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $error("no transfer for %0d cycles, %0d results outstanding", stuck_cycles,
             sb.outstanding());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // result side back-pressure: long hold on request, random bursts otherwise unless quiet
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        result_stall <= 1'b0;
      end else if (burst_left > 0) begin
        result_stall <= 1'b1;
        burst_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        burst_left = $urandom_range(0, 5);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  task automatic send_pull(input logic [3:0] arm, input logic [16:0] reward);
    @(negedge clk);
    item       <= '{arm_index: arm, reward: reward};
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    item_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic [16:0] pick_reward();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 17'($urandom_range(0, 65536));
    if (sel < 8) return 17'($urandom);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return FIXED_ONE;
      2:       return FIXED_ONE - 17'd1;
      default: return '1;
    endcase
  endfunction

  task automatic random_pull(input bit hot_arms);
    logic [3:0] arm;
    if (!quiet && $urandom_range(0, 4) == 0) idle_gap($urandom_range(1, 6));
    arm = hot_arms ? 4'($urandom_range(0, 3)) : 4'($urandom);
    send_pull(arm, pick_reward());
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // all means zero: tie resolves to arm 0
    send_pull(4'd0, 17'd0);
    send_pull(4'd9, 17'd1);
    send_pull(4'd15, FIXED_ONE);
    // clamped rewards tie with arm 15 at 1.0
    send_pull(4'd7, '1);
    send_pull(4'd3, FIXED_ONE + 17'd1);
    send_pull(4'd3, 17'd0);
    send_pull(4'd2, FIXED_ONE - 17'd1);
    idle_gap(3);
    send_pull(4'd5, 17'd3);
    send_pull(4'd5, 17'd4);
    send_pull(4'd5, FIXED_ONE - 17'd1);
    send_pull(4'd5, 17'd0);
    send_pull(4'd5, 17'h15555);
    send_pull(4'd5, 17'h0AAAA);
    send_pull(4'd10, 17'h10000);
    send_pull(4'd4, 17'h0FFFF);
    send_pull(4'd15, 17'd0);
    send_pull(4'd15, 17'd0);
    send_pull(4'd7, 17'd1);
    send_pull(4'd8, 17'h1FFFE);
    send_pull(4'd1, 17'h0F0F0);
    send_pull(4'd6, 17'h00F0F);

    repeat (350) random_pull(1'b0);

    // sender pause until the block is empty
    idle_gap(1);
    drain_results();

    // long receiver hold while items keep coming
    hold_req = LONG_HOLD;
    repeat (20) send_pull(4'($urandom), pick_reward());

    repeat (300) random_pull(1'b1);
    repeat (280) random_pull(1'b0);
    quiet = 1'b1;
    repeat (150) random_pull(1'b0);

    @(negedge clk);
    item_valid <= 1'b0;
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d pulls on %0d arms, %0d results checked, %0d rewards clamped,",
             sb.pulls, ARM_COUNT, sb.checked, sb.clamped);
    $display("with argmax ties, repeated pulls on hot arms and a long result hold-off.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
